// ----- hdl/cfps_pkg.sv -----
// ----------------------------------------------------------------------------
// cfps_pkg
// Shared sizes, opcodes and status codes for the compressed prefix-sum block.
// ----------------------------------------------------------------------------
package cfps_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int SUM_W    = 64;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_ADD   = 2'd1;
	localparam opcode_t OP_QUERY = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_LOAD_LATE = 2'd2;
	localparam status_t ST_KEY_DESC  = 2'd3;

endpackage

// ----- hdl/compressed_fenwick_prefix_sum_top.sv -----
// ----------------------------------------------------------------------------
// compressed_fenwick_prefix_sum_top
// Binary indexed tree over a sorted key table, both held in synchronous RAM.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   input    | in_valid/in_ready  | opcode, key, weight
//   output   | out_valid/out_ready| prefix_total, status
//
// A load goes through S_LOAD to S_FIN. An add or query does a binary search over the key
// table, each step a RAM read and then a compare, then walks the tree RAM a cell
// at a time (read, then write or accumulate), up to log2(CAPACITY)+1 cells.
// After reset every cell of the tree RAM is swept to zero, with in_ready low.
// A result waits in the output register; a following item is taken meanwhile,
// and only its final step stalls if the output is still occupied.
// ----------------------------------------------------------------------------
module compressed_fenwick_prefix_sum_top
	import cfps_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              opcode,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [31:0]      weight,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] prefix_total,
	output logic [1:0]              status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOAD   = 4'd1;
	localparam logic [3:0] S_SRD    = 4'd2;
	localparam logic [3:0] S_SCMP   = 4'd3;
	localparam logic [3:0] S_ADD_RD = 4'd4;
	localparam logic [3:0] S_ADD_WR = 4'd5;
	localparam logic [3:0] S_Q_RD   = 4'd6;
	localparam logic [3:0] S_Q_ACC  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0]              state_q;
	logic                    clr_active_q;
	logic [IDX_W-1:0]        clr_idx_q;
	logic [CNT_W-1:0]        key_count_q;
	logic                    adds_started_q;
	logic signed [KEY_W-1:0] last_key_q;

	opcode_t                 op_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [31:0]      weight_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi_q;
	logic [CNT_W-1:0]        mid_q;
	logic [CNT_W-1:0]        i_q;
	logic [SUM_W-1:0]        total_q;
	status_t                 res_status_q;

	logic                    out_valid_q;
	logic [SUM_W-1:0]        prefix_total_q;
	status_t                 status_q;

	logic [KEY_W-1:0]        key_mem [CAPACITY];
	logic [SUM_W-1:0]        tree_mem [CAPACITY];
	logic signed [KEY_W-1:0] key_rd;
	logic [SUM_W-1:0]        tree_rd;

	logic [CNT_W-1:0]        mid;
	logic                    key_we;
	logic                    tree_we;
	logic [IDX_W-1:0]        tree_wa;
	logic [SUM_W-1:0]        tree_wd;
	logic                    go_right;
	logic [CNT_W-1:0]        base;
	logic                    out_free;
	logic                    in_xfer;
	logic [SUM_W-1:0]        weight_ext;

	assign in_ready     = (state_q == S_IDLE) && !clr_active_q;
	assign in_xfer      = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign prefix_total = prefix_total_q;
	assign status       = status_q;
	assign out_free     = !out_valid_q || out_ready;

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign weight_ext = {{(SUM_W-32){weight_q[31]}}, weight_q};
	assign base       = i_q & (i_q + CNT_W'(1));
	// adds look for the first key >= k, queries count keys <= k
	assign go_right   = (op_q == OP_ADD) ? (key_rd < key_q) : (key_rd <= key_q);

	assign key_we  = (state_q == S_LOAD) && (key_count_q != CNT_W'(CAPACITY))
		&& !adds_started_q && !((key_count_q != '0) && (key_q < last_key_q));
	assign tree_we = clr_active_q || (state_q == S_ADD_WR);
	assign tree_wa = clr_active_q ? clr_idx_q : i_q[IDX_W-1:0];
	assign tree_wd = clr_active_q ? '0 : (tree_rd + weight_ext);

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_count_q[IDX_W-1:0]] <= key_q;
		key_rd <= key_mem[mid[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tree_we)
			tree_mem[tree_wa] <= tree_wd;
		tree_rd <= tree_mem[i_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= opcode;
			key_q    <= key;
			weight_q <= weight;
			lo_q     <= '0;
			hi_q     <= key_count_q;
			total_q  <= '0;
		end
		if (key_we)
			last_key_q <= key_q;
		case (state_q)
			S_LOAD: begin
				if (key_count_q == CNT_W'(CAPACITY))
					res_status_q <= ST_FULL;
				else if (adds_started_q)
					res_status_q <= ST_LOAD_LATE;
				else if (!key_we)
					res_status_q <= ST_KEY_DESC;
				else
					res_status_q <= ST_OK;
			end
			S_SRD: begin
				mid_q        <= mid;
				res_status_q <= ST_OK;
				if (lo_q >= hi_q)
					i_q <= (op_q == OP_ADD) ? lo_q : lo_q - CNT_W'(1);
			end
			S_SCMP: begin
				if (go_right)
					lo_q <= mid_q + CNT_W'(1);
				else
					hi_q <= mid_q;
			end
			S_ADD_WR: i_q <= i_q | (i_q + CNT_W'(1));
			S_Q_ACC: begin
				total_q <= total_q + tree_rd;
				i_q     <= base - CNT_W'(1);
			end
			S_IDLE: res_status_q <= ST_OK;
			default: ;
		endcase
		if (state_q == S_FIN && out_free) begin
			prefix_total_q <= total_q;
			status_q       <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			clr_active_q   <= 1'b1;
			clr_idx_q      <= '0;
			key_count_q    <= '0;
			adds_started_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(CAPACITY - 1))
					clr_active_q <= 1'b0;
			end
			if (key_we)
				key_count_q <= key_count_q + CNT_W'(1);
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (opcode)
							OP_LOAD: state_q <= S_LOAD;
							OP_ADD: begin
								state_q        <= S_SRD;
								adds_started_q <= 1'b1;
							end
							OP_QUERY: state_q <= S_SRD;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_LOAD: state_q <= S_FIN;
				S_SRD: begin
					if (lo_q < hi_q)
						state_q <= S_SCMP;
					else if (op_q == OP_ADD)
						state_q <= S_ADD_RD;
					else if (lo_q == '0)
						state_q <= S_FIN;
					else
						state_q <= S_Q_RD;
				end
				S_SCMP: state_q <= S_SRD;
				S_ADD_RD: state_q <= (i_q < key_count_q) ? S_ADD_WR : S_FIN;
				S_ADD_WR: state_q <= S_ADD_RD;
				S_Q_RD: state_q <= S_Q_ACC;
				S_Q_ACC: state_q <= (base == '0) ? S_FIN : S_Q_RD;
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CNT_W'(CAPACITY))
		else $error("key count beyond capacity");

	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_WR) |-> (i_q < key_count_q))
		else $error("tree update outside loaded slots");

	a_no_load_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && adds_started_q) |=> (key_count_q == $past(key_count_q)))
		else $error("key appended after an add");

	a_no_accept_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_ready)
		else $error("transfer taken during tree clear");
`endif

endmodule
